FILE: src/sxl_pkg.sv
// Package for the s-expression lexer: scanner modes, token and error codes,
// record kinds and character classes. Used by sexpr_lexer; no dependencies.
package sxl_pkg;

   typedef enum logic [13:0] {
      MODE_IDLE     = 14'b00000000000001,
      MODE_STR      = 14'b00000000000010,
      MODE_STR_ESC  = 14'b00000000000100,
      MODE_NUM_INT  = 14'b00000000001000,
      MODE_NUM_FRAC = 14'b00000000010000,
      MODE_NUM_EXP  = 14'b00000000100000,
      MODE_KW_START = 14'b00000001000000,
      MODE_KW_BARE  = 14'b00000010000000,
      MODE_KWQ      = 14'b00000100000000,
      MODE_KWQ_TAKE = 14'b00001000000000,
      MODE_IDENT    = 14'b00010000000000,
      MODE_ARROW2   = 14'b00100000000000,
      MODE_CMT2     = 14'b01000000000000,
      MODE_COMMENT  = 14'b10000000000000
   } mode_type;

   localparam logic [1:0] KIND_VALUE = 2'd0;
   localparam logic [1:0] KIND_TOKEN = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [3:0] TOK_LPAREN   = 4'd0;
   localparam logic [3:0] TOK_RPAREN   = 4'd1;
   localparam logic [3:0] TOK_LBRACKET = 4'd2;
   localparam logic [3:0] TOK_RBRACKET = 4'd3;
   localparam logic [3:0] TOK_STRING   = 4'd4;
   localparam logic [3:0] TOK_INT      = 4'd5;
   localparam logic [3:0] TOK_FLOAT    = 4'd6;
   localparam logic [3:0] TOK_BOOL     = 4'd7;
   localparam logic [3:0] TOK_KEYWORD  = 4'd8;
   localparam logic [3:0] TOK_IDENT    = 4'd9;
   localparam logic [3:0] TOK_ARROW    = 4'd10;
   localparam logic [3:0] TOK_COMMENT  = 4'd11;
   localparam logic [3:0] TOK_EOF      = 4'd12;
   localparam logic [3:0] TOK_NONE     = 4'd0;

   localparam logic [2:0] ERR_UNEXPECTED  = 3'd0;
   localparam logic [2:0] ERR_ESC_AT_END  = 3'd1;
   localparam logic [2:0] ERR_UNKNOWN_ESC = 3'd2;
   localparam logic [2:0] ERR_OPEN_STRING = 3'd3;
   localparam logic [2:0] ERR_EXP_DIGITS  = 3'd4;
   localparam logic [2:0] ERR_OPEN_QKW    = 3'd5;
   localparam logic [2:0] ERR_EMPTY_KW    = 3'd6;
   localparam logic [2:0] ERR_BARE_DOLLAR = 3'd7;
   localparam logic [2:0] ERR_NONE        = 3'd0;

   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_DOLLAR   = 8'h24;
   localparam logic [7:0] CH_GT       = 8'h3E;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_NL       = 8'h0A;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_VT       = 8'h0B;
   localparam logic [7:0] CH_FF       = 8'h0C;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_LOW_E    = 8'h65;
   localparam logic [7:0] CH_UP_E     = 8'h45;
   localparam logic [7:0] CH_LOW_N    = 8'h6E;
   localparam logic [7:0] CH_LOW_T    = 8'h74;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == CH_MINUS) || (c == 8'h5F) || (c == CH_DOT) || (c == 8'h2F);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
   endfunction

   function automatic logic is_cmt_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) ||
             (c == CH_FF);
   endfunction

   // Prefix tracker for "true" (ends in 5) and "false" (ends in 10).
   function automatic logic [3:0] bool_next(input logic [3:0] s, input logic [7:0] c);
      logic [3:0] r;
      r = 4'd0;
      case (s)
         4'd1: r = (c == 8'h74) ? 4'd2 : ((c == 8'h66) ? 4'd6 : 4'd0);
         4'd2: r = (c == 8'h72) ? 4'd3 : 4'd0;
         4'd3: r = (c == 8'h75) ? 4'd4 : 4'd0;
         4'd4: r = (c == 8'h65) ? 4'd5 : 4'd0;
         4'd6: r = (c == 8'h61) ? 4'd7 : 4'd0;
         4'd7: r = (c == 8'h6C) ? 4'd8 : 4'd0;
         4'd8: r = (c == 8'h73) ? 4'd9 : 4'd0;
         4'd9: r = (c == 8'h65) ? 4'd10 : 4'd0;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: src/sexpr_lexer.sv
// S-expression lexer top level: scanner with one byte of lookahead and a record buffer.
// Depends on sxl_pkg.
// The first record of an item is offered in the cycle after its transfer.
// One item per cycle while the previous item left at most one record, taken that cycle;
// else req_stall holds; the record buffer drains one record per cycle while rsp_stall is low.
// Reset is synchronous: scanner returns to idle at line 1, column 1, offset 0,
// comments are dropped, and the record buffer is emptied.
module sexpr_lexer
   import sxl_pkg::*;
#(
   parameter int LINE_BITS   = 16,
   parameter int OFFSET_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_ch,
   input  logic                   req_end_of_source,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_record_kind,
   output logic [3:0]             rsp_token_type,
   output logic [2:0]             rsp_error_code,
   output logic [7:0]             rsp_value_char,
   output logic [LINE_BITS-1:0]   rsp_start_line,
   output logic [LINE_BITS-1:0]   rsp_start_column,
   output logic [OFFSET_BITS-1:0] rsp_start_offset,
   output logic [OFFSET_BITS-1:0] rsp_span_length,
   output logic [LINE_BITS-1:0]   rsp_end_line,
   output logic [LINE_BITS-1:0]   rsp_end_column,
   output logic                   rsp_last_record,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0]   LINE_TOP = {LINE_BITS{1'b1}};
   localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
   localparam logic [OFFSET_BITS-1:0] OFF_TOP  = {OFFSET_BITS{1'b1}};

   typedef struct packed {
      logic [1:0]             kind;
      logic [3:0]             ttype;
      logic [2:0]             err;
      logic [7:0]             val;
      logic [LINE_BITS-1:0]   sl;
      logic [LINE_BITS-1:0]   sc;
      logic [OFFSET_BITS-1:0] so;
      logic [OFFSET_BITS-1:0] span;
      logic [LINE_BITS-1:0]   el;
      logic [LINE_BITS-1:0]   ec;
   } rec_type;

   function automatic rec_type mk(
      input logic [1:0] kind, input logic [3:0] ttype, input logic [2:0] err,
      input logic [7:0] val, input logic [LINE_BITS-1:0] sl,
      input logic [LINE_BITS-1:0] sc, input logic [OFFSET_BITS-1:0] so,
      input logic [OFFSET_BITS-1:0] span, input logic [LINE_BITS-1:0] el,
      input logic [LINE_BITS-1:0] ec);
      rec_type r;
      r.kind = kind; r.ttype = ttype; r.err = err; r.val = val;
      r.sl = sl; r.sc = sc; r.so = so; r.span = span; r.el = el; r.ec = ec;
      return r;
   endfunction

   function automatic rec_type mk_val(input logic [7:0] v);
      return mk(KIND_VALUE, TOK_NONE, ERR_NONE, v, '0, '0, '0, '0, '0, '0);
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_l(input logic [LINE_BITS-1:0] v);
      return (v == LINE_TOP) ? v : v + LINE_ONE;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] sat_o(input logic [OFFSET_BITS-1:0] v);
      return (v == OFF_TOP) ? v : v + OFF_ONE;
   endfunction

   logic                   keep_ff;
   mode_type               mode_ff, mode_in;
   logic [7:0]             held_ff, held_in;
   logic                   hv_ff, hv_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, col_ff, col_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [LINE_BITS-1:0]   tline_ff, tline_in, tcol_ff, tcol_in;
   logic [OFFSET_BITS-1:0] toff_ff, toff_in;
   logic [3:0]             bm_ff, bm_in;
   logic [3:0]             flags_ff, flags_in;

   rec_type                recs_ff [8];
   rec_type                recs_in [8];
   logic [3:0]             cnt_ff, n_in;
   logic [3:0]             rd_ff;
   logic                   req_take, rsp_take;
   logic [3:0]             pending;

   assign pending   = cnt_ff - rd_ff;
   assign rsp_valid = (rd_ff != cnt_ff);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = !((pending == 4'd0) || ((pending == 4'd1) && !rsp_stall));
   assign req_take  = req_valid && !req_stall;

   assign pready = 1'b1;
   assign prdata = {31'd0, keep_ff};

   always_comb begin
      logic [7:0]             c, la, v;
      logic                   fall;
      logic [LINE_BITS-1:0]   back_l;
      logic [OFFSET_BITS-1:0] back_o, s;
      c = held_ff;
      la = req_end_of_source ? 8'd0 : req_ch;
      fall = 1'b0;
      back_l = '0;
      back_o = '0;
      s = '0;
      mode_in = mode_ff; held_in = held_ff; hv_in = hv_ff;
      line_in = line_ff; col_in = col_ff; off_in = off_ff;
      tline_in = tline_ff; tcol_in = tcol_ff; toff_in = toff_ff;
      bm_in = bm_ff; flags_in = flags_ff;
      n_in = 4'd0;
      for (int i = 0; i < 8; i++) begin
         recs_in[i] = mk_val(8'd0);
      end

      if (hv_ff) begin
         case (mode_in)
            MODE_STR: begin
               off_in = sat_o(off_in);
               if (c == CH_NL) begin line_in = sat_l(line_in); col_in = LINE_ONE; end
               else col_in = sat_l(col_in);
               if (c == CH_QUOTE) begin
                  recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_STRING, ERR_NONE, 8'd0, tline_in,
                     tcol_in, toff_in, off_in - toff_in, line_in, col_in);
                  n_in = n_in + 4'd1;
                  mode_in = MODE_IDLE; flags_in = '0; bm_in = '0;
               end else if (c == CH_BSLASH) begin
                  mode_in = MODE_STR_ESC;
               end else begin
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
               end
            end
            MODE_STR_ESC: begin
               v = c;
               if (c == CH_LOW_N) v = CH_NL;
               else if (c == CH_LOW_T) v = CH_TAB;
               else if (c != CH_QUOTE && c != CH_BSLASH) begin
                  recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_UNKNOWN_ESC, 8'd0,
                     line_in, col_in - LINE_ONE, off_in - OFF_ONE, OFFSET_BITS'(2), '0, '0);
                  n_in = n_in + 4'd1;
               end
               off_in = sat_o(off_in);
               if (c == CH_NL) begin line_in = sat_l(line_in); col_in = LINE_ONE; end
               else col_in = sat_l(col_in);
               recs_in[n_in[2:0]] = mk_val(v); n_in = n_in + 4'd1;
               mode_in = MODE_STR;
            end
            MODE_NUM_INT, MODE_NUM_FRAC, MODE_NUM_EXP: begin
               if (mode_in != MODE_NUM_EXP && is_digit(c)) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
               end else if (mode_in == MODE_NUM_INT && c == CH_DOT && is_digit(la)) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                  flags_in = flags_in | 4'd1; mode_in = MODE_NUM_FRAC;
               end else if (mode_in != MODE_NUM_EXP && (c == CH_LOW_E || c == CH_UP_E)) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                  flags_in = flags_in | 4'd3; mode_in = MODE_NUM_EXP;
               end else if (mode_in == MODE_NUM_EXP && flags_in[1] &&
                            (c == CH_PLUS || c == CH_MINUS)) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                  flags_in = (flags_in & 4'b1101) | 4'd8;
               end else if (mode_in == MODE_NUM_EXP && is_digit(c)) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                  flags_in = (flags_in & 4'b1101) | 4'd4;
               end else begin
                  if (mode_in == MODE_NUM_EXP && !flags_in[2]) begin
                     back_l = flags_in[3] ? LINE_BITS'(2) : LINE_ONE;
                     back_o = flags_in[3] ? OFFSET_BITS'(2) : OFF_ONE;
                     recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_EXP_DIGITS, 8'd0,
                        line_in, col_in - back_l, off_in - back_o, back_o, '0, '0);
                     n_in = n_in + 4'd1;
                  end
                  recs_in[n_in[2:0]] = mk(KIND_TOKEN, flags_in[0] ? TOK_FLOAT : TOK_INT,
                     ERR_NONE, 8'd0, tline_in, tcol_in, toff_in, off_in - toff_in,
                     line_in, col_in);
                  n_in = n_in + 4'd1;
                  fall = 1'b1;
               end
            end
            MODE_KW_START, MODE_KW_BARE: begin
               if (mode_in == MODE_KW_START && c == CH_QUOTE) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  mode_in = MODE_KWQ;
               end else if (is_ident(c) || is_digit(c)) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                  flags_in = flags_in | 4'd2; mode_in = MODE_KW_BARE;
               end else begin
                  if (!flags_in[1]) begin
                     recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_EMPTY_KW, 8'd0,
                        tline_in, tcol_in, toff_in, OFF_ONE, '0, '0);
                     n_in = n_in + 4'd1;
                  end
                  recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_KEYWORD, ERR_NONE, 8'd0, tline_in,
                     tcol_in, toff_in, off_in - toff_in, line_in, col_in);
                  n_in = n_in + 4'd1;
                  fall = 1'b1;
               end
            end
            MODE_KWQ: begin
               off_in = sat_o(off_in);
               if (c == CH_NL) begin line_in = sat_l(line_in); col_in = LINE_ONE; end
               else col_in = sat_l(col_in);
               if (c == CH_QUOTE) begin
                  recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_KEYWORD, ERR_NONE, 8'd0, tline_in,
                     tcol_in, toff_in, off_in - toff_in, line_in, col_in);
                  n_in = n_in + 4'd1;
                  mode_in = MODE_IDLE; flags_in = '0; bm_in = '0;
               end else if (c == CH_BSLASH && la == CH_QUOTE) begin
                  mode_in = MODE_KWQ_TAKE;
               end else begin
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
               end
            end
            MODE_KWQ_TAKE: begin
               off_in = sat_o(off_in);
               if (c == CH_NL) begin line_in = sat_l(line_in); col_in = LINE_ONE; end
               else col_in = sat_l(col_in);
               recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
               mode_in = MODE_KWQ;
            end
            MODE_IDENT: begin
               if (is_ident(c) || is_digit(c)) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                  flags_in = flags_in | 4'd2; bm_in = bool_next(bm_in, c);
               end else begin
                  if (flags_in[0] && !flags_in[1]) begin
                     recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_BARE_DOLLAR, 8'd0,
                        tline_in, tcol_in, toff_in, OFF_ONE, '0, '0);
                     n_in = n_in + 4'd1;
                  end
                  recs_in[n_in[2:0]] = mk(KIND_TOKEN,
                     (bm_in == 4'd5 || bm_in == 4'd10) ? TOK_BOOL : TOK_IDENT, ERR_NONE,
                     8'd0, tline_in, tcol_in, toff_in, off_in - toff_in, line_in, col_in);
                  n_in = n_in + 4'd1;
                  fall = 1'b1;
               end
            end
            MODE_ARROW2: begin
               off_in = sat_o(off_in);
               if (c == CH_NL) begin line_in = sat_l(line_in); col_in = LINE_ONE; end
               else col_in = sat_l(col_in);
               recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_ARROW, ERR_NONE, 8'd0, tline_in,
                  tcol_in, toff_in, off_in - toff_in, line_in, col_in);
               n_in = n_in + 4'd1;
               mode_in = MODE_IDLE; flags_in = '0; bm_in = '0;
            end
            MODE_CMT2: begin
               off_in = sat_o(off_in);
               if (c == CH_NL) begin line_in = sat_l(line_in); col_in = LINE_ONE; end
               else col_in = sat_l(col_in);
               mode_in = MODE_COMMENT; flags_in = 4'd1;
            end
            MODE_COMMENT: begin
               if (c == CH_NL) begin
                  if (keep_ff) begin
                     recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_COMMENT, ERR_NONE, 8'd0,
                        tline_in, tcol_in, toff_in, off_in - toff_in, line_in, col_in);
                     n_in = n_in + 4'd1;
                  end
                  fall = 1'b1;
               end else begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  if (!(flags_in[0] && is_cmt_blank(c))) begin
                     flags_in = flags_in & 4'b1110;
                     if (keep_ff) begin
                        recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                     end
                  end
               end
            end
            default: fall = 1'b1;
         endcase

         if (fall) begin
            mode_in = MODE_IDLE; flags_in = '0; bm_in = '0;
            if (is_blank(c)) begin
               off_in = sat_o(off_in);
               if (c == CH_NL) begin line_in = sat_l(line_in); col_in = LINE_ONE; end
               else col_in = sat_l(col_in);
            end else begin
               tline_in = line_in; tcol_in = col_in; toff_in = off_in;
               if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACKET ||
                   c == CH_RBRACKET) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk(KIND_TOKEN,
                     (c == CH_LPAREN) ? TOK_LPAREN : (c == CH_RPAREN) ? TOK_RPAREN :
                     (c == CH_LBRACKET) ? TOK_LBRACKET : TOK_RBRACKET, ERR_NONE, 8'd0,
                     tline_in, tcol_in, toff_in, off_in - toff_in, line_in, col_in);
                  n_in = n_in + 4'd1;
               end else if (c == CH_QUOTE) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  mode_in = MODE_STR;
               end else if (c == CH_SEMI && la == CH_SEMI) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  mode_in = MODE_CMT2;
               end else if (c == CH_COLON) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  mode_in = MODE_KW_START;
               end else if (c == CH_MINUS && la == CH_GT) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  mode_in = MODE_ARROW2;
               end else if ((c == CH_MINUS && is_digit(la)) || is_digit(c)) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                  mode_in = MODE_NUM_INT;
               end else if (c == CH_DOLLAR) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                  flags_in = 4'd1; mode_in = MODE_IDENT;
               end else if (is_ident(c)) begin
                  off_in = sat_o(off_in); col_in = sat_l(col_in);
                  recs_in[n_in[2:0]] = mk_val(c); n_in = n_in + 4'd1;
                  flags_in = 4'd2; bm_in = bool_next(4'd1, c); mode_in = MODE_IDENT;
               end else begin
                  recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_UNEXPECTED, 8'd0,
                     line_in, col_in, off_in, OFF_ONE, '0, '0);
                  n_in = n_in + 4'd1;
                  off_in = sat_o(off_in);
                  if (c == CH_NL) begin line_in = sat_l(line_in); col_in = LINE_ONE; end
                  else col_in = sat_l(col_in);
               end
            end
         end
      end

      if (req_end_of_source) begin
         s = off_in - toff_in;
         if (s == '0) s = OFF_ONE;
         case (mode_in)
            MODE_STR, MODE_STR_ESC: begin
               if (mode_in == MODE_STR_ESC) begin
                  recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_ESC_AT_END, 8'd0,
                     line_in, col_in, off_in, OFF_ONE, '0, '0);
                  n_in = n_in + 4'd1;
               end
               recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_OPEN_STRING, 8'd0,
                  tline_in, tcol_in, toff_in, s, '0, '0);
               n_in = n_in + 4'd1;
               recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_STRING, ERR_NONE, 8'd0, tline_in,
                  tcol_in, toff_in, off_in - toff_in, line_in, col_in);
               n_in = n_in + 4'd1;
            end
            MODE_NUM_INT, MODE_NUM_FRAC, MODE_NUM_EXP: begin
               if (mode_in == MODE_NUM_EXP && !flags_in[2]) begin
                  back_l = flags_in[3] ? LINE_BITS'(2) : LINE_ONE;
                  back_o = flags_in[3] ? OFFSET_BITS'(2) : OFF_ONE;
                  recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_EXP_DIGITS, 8'd0,
                     line_in, col_in - back_l, off_in - back_o, back_o, '0, '0);
                  n_in = n_in + 4'd1;
               end
               recs_in[n_in[2:0]] = mk(KIND_TOKEN, flags_in[0] ? TOK_FLOAT : TOK_INT,
                  ERR_NONE, 8'd0, tline_in, tcol_in, toff_in, off_in - toff_in,
                  line_in, col_in);
               n_in = n_in + 4'd1;
            end
            MODE_KW_START, MODE_KW_BARE: begin
               if (!flags_in[1]) begin
                  recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_EMPTY_KW, 8'd0,
                     tline_in, tcol_in, toff_in, OFF_ONE, '0, '0);
                  n_in = n_in + 4'd1;
               end
               recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_KEYWORD, ERR_NONE, 8'd0, tline_in,
                  tcol_in, toff_in, off_in - toff_in, line_in, col_in);
               n_in = n_in + 4'd1;
            end
            MODE_KWQ, MODE_KWQ_TAKE: begin
               recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_OPEN_QKW, 8'd0,
                  tline_in, tcol_in, toff_in, s, '0, '0);
               n_in = n_in + 4'd1;
               recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_KEYWORD, ERR_NONE, 8'd0, tline_in,
                  tcol_in, toff_in, off_in - toff_in, line_in, col_in);
               n_in = n_in + 4'd1;
            end
            MODE_IDENT: begin
               if (flags_in[0] && !flags_in[1]) begin
                  recs_in[n_in[2:0]] = mk(KIND_ERROR, TOK_NONE, ERR_BARE_DOLLAR, 8'd0,
                     tline_in, tcol_in, toff_in, OFF_ONE, '0, '0);
                  n_in = n_in + 4'd1;
               end
               recs_in[n_in[2:0]] = mk(KIND_TOKEN,
                  (bm_in == 4'd5 || bm_in == 4'd10) ? TOK_BOOL : TOK_IDENT, ERR_NONE,
                  8'd0, tline_in, tcol_in, toff_in, off_in - toff_in, line_in, col_in);
               n_in = n_in + 4'd1;
            end
            MODE_ARROW2: begin
               recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_ARROW, ERR_NONE, 8'd0, tline_in,
                  tcol_in, toff_in, off_in - toff_in, line_in, col_in);
               n_in = n_in + 4'd1;
            end
            MODE_CMT2, MODE_COMMENT: begin
               if (keep_ff) begin
                  recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_COMMENT, ERR_NONE, 8'd0,
                     tline_in, tcol_in, toff_in, off_in - toff_in, line_in, col_in);
                  n_in = n_in + 4'd1;
               end
            end
            default: ;
         endcase
         recs_in[n_in[2:0]] = mk(KIND_TOKEN, TOK_EOF, ERR_NONE, 8'd0, line_in, col_in,
            off_in, '0, line_in, col_in);
         n_in = n_in + 4'd1;
         mode_in = MODE_IDLE; flags_in = '0; bm_in = '0;
         held_in = 8'd0; hv_in = 1'b0;
         line_in = LINE_ONE; col_in = LINE_ONE; off_in = '0;
         tline_in = LINE_ONE; tcol_in = LINE_ONE; toff_in = '0;
      end else begin
         held_in = req_ch;
         hv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b0;
         mode_ff <= MODE_IDLE;
         held_ff <= 8'd0;
         hv_ff <= 1'b0;
         line_ff <= LINE_ONE;
         col_ff <= LINE_ONE;
         off_ff <= '0;
         tline_ff <= LINE_ONE;
         tcol_ff <= LINE_ONE;
         toff_ff <= '0;
         bm_ff <= '0;
         flags_ff <= '0;
         cnt_ff <= 4'd0;
         rd_ff <= 4'd0;
      end else begin
         if (psel && penable && pwrite && pready && !paddr[2]) begin
            keep_ff <= pwdata[0];
         end
         if (req_take) begin
            mode_ff <= mode_in;
            held_ff <= held_in;
            hv_ff <= hv_in;
            line_ff <= line_in;
            col_ff <= col_in;
            off_ff <= off_in;
            tline_ff <= tline_in;
            tcol_ff <= tcol_in;
            toff_ff <= toff_in;
            bm_ff <= bm_in;
            flags_ff <= flags_in;
            cnt_ff <= n_in;
            rd_ff <= 4'd0;
         end else if (rsp_take) begin
            rd_ff <= rd_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         recs_ff <= recs_in;
      end
   end

   assign rsp_record_kind  = recs_ff[rd_ff[2:0]].kind;
   assign rsp_token_type   = recs_ff[rd_ff[2:0]].ttype;
   assign rsp_error_code   = recs_ff[rd_ff[2:0]].err;
   assign rsp_value_char   = recs_ff[rd_ff[2:0]].val;
   assign rsp_start_line   = recs_ff[rd_ff[2:0]].sl;
   assign rsp_start_column = recs_ff[rd_ff[2:0]].sc;
   assign rsp_start_offset = recs_ff[rd_ff[2:0]].so;
   assign rsp_span_length  = recs_ff[rd_ff[2:0]].span;
   assign rsp_end_line     = recs_ff[rd_ff[2:0]].el;
   assign rsp_end_column   = recs_ff[rd_ff[2:0]].ec;
   assign rsp_last_record  = ((rd_ff + 4'd1) == cnt_ff);

   // A new item may only overwrite the buffer once its last record leaves.
   assert property (@(posedge clock) disable iff (reset)
      req_take |-> ((rd_ff == cnt_ff) || ((rd_ff + 4'd1) == cnt_ff && rsp_take)))
      else $error("record buffer overwritten while records were pending");

   assert property (@(posedge clock) disable iff (reset)
      (rd_ff <= cnt_ff) && (cnt_ff <= 4'd8))
      else $error("record buffer pointers out of range");

   // The end marker always yields at least the end-of-file record and clears lookahead.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_end_of_source) |=> (rsp_valid && !hv_ff))
      else $error("end of source did not flush the scanner");

endmodule

FILE: tb/tb_top.sv
// Testbench for sexpr_lexer: byte streams go in on the request channel and every
// token, text and error record is checked against a built-in predictor.
// Depends on sxl_pkg and sexpr_lexer.
`timescale 1ns / 100ps

module tb_top;
   import sxl_pkg::*;

   localparam logic [2:0] ADDR_KEEP_COMMENTS = 3'd0;
   localparam int unsigned LINE_TOP = 65535;
   localparam int unsigned OFF_TOP = 16777215;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
   } src_byte_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  ttype;
      logic [2:0]  err;
      logic [7:0]  val;
      logic [15:0] sl;
      logic [15:0] sc;
      logic [23:0] so;
      logic [23:0] span;
      logic [15:0] el;
      logic [15:0] ec;
      logic        last;
   } lex_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_ch = 8'd0;
   logic req_end_of_source = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_record_kind;
   logic [3:0] rsp_token_type;
   logic [2:0] rsp_error_code;
   logic [7:0] rsp_value_char;
   logic [15:0] rsp_start_line, rsp_start_column, rsp_end_line, rsp_end_column;
   logic [23:0] rsp_start_offset, rsp_span_length;
   logic rsp_last_record;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic pready;

   sexpr_lexer uut (.*);

   src_byte_type   source_q[$];
   lex_record_type record_q[$];
   int unsigned send_idle_pct = 20;
   int unsigned recv_stall_pct = 54;
   int unsigned cycle_count = 0;
   bit          failed = 1'b0;

   // Predictor state.
   mode_type    lx_mode = MODE_IDLE;
   logic [7:0]  hold_ch = 8'd0;
   bit          hold_ok = 1'b0;
   int unsigned cur_line = 1, cur_col = 1, cur_off = 0;
   int unsigned tk_line = 1, tk_col = 1, tk_off = 0;
   logic [3:0]  bmatch = 4'd0;
   logic [3:0]  sflags = 4'd0;
   bit          keep_cmt = 1'b0;
   int unsigned step_n;

   string ident_set = "abcdefghijklmnopqrstuvwxyzAFTXZ-_./";

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic bit dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit idc(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "-" ||
             c == "_" || c == "." || c == "/";
   endfunction

   function automatic bit cmt_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
   endfunction

   function automatic int unsigned sat(int unsigned v, int unsigned top);
      return (v >= top) ? top : v + 1;
   endfunction

   function automatic logic [3:0] bool_step(logic [3:0] s, logic [7:0] c);
      case (s)
         4'd1: return (c == "t") ? 4'd2 : ((c == "f") ? 4'd6 : 4'd0);
         4'd2: return (c == "r") ? 4'd3 : 4'd0;
         4'd3: return (c == "u") ? 4'd4 : 4'd0;
         4'd4: return (c == "e") ? 4'd5 : 4'd0;
         4'd6: return (c == "a") ? 4'd7 : 4'd0;
         4'd7: return (c == "l") ? 4'd8 : 4'd0;
         4'd8: return (c == "s") ? 4'd9 : 4'd0;
         4'd9: return (c == "e") ? 4'd10 : 4'd0;
         default: return 4'd0;
      endcase
   endfunction

   task automatic put(logic [1:0] kind, logic [3:0] ttype, logic [2:0] err, logic [7:0] val,
                      int unsigned sl, int unsigned sc, int unsigned so, int unsigned span,
                      int unsigned el, int unsigned ec);
      lex_record_type r;
      if (step_n < 8) begin
         r = '{kind, ttype, err, val, sl[15:0], sc[15:0], so[23:0], span[23:0],
               el[15:0], ec[15:0], 1'b0};
         record_q.push_back(r);
         step_n++;
      end
   endtask

   task automatic put_val(logic [7:0] c);
      put(KIND_VALUE, TOK_NONE, ERR_NONE, c, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic put_err(logic [2:0] code, int unsigned l, int unsigned c, int unsigned o,
                          int unsigned span);
      put(KIND_ERROR, TOK_NONE, code, 8'd0, l, c, o, span, 0, 0);
   endtask

   task automatic put_tok(logic [3:0] t);
      put(KIND_TOKEN, t, ERR_NONE, 8'd0, tk_line, tk_col, tk_off, cur_off - tk_off,
          cur_line, cur_col);
   endtask

   function automatic int unsigned open_span();
      return (cur_off - tk_off < 1) ? 1 : cur_off - tk_off;
   endfunction

   task automatic advance(logic [7:0] c);
      cur_off = sat(cur_off, OFF_TOP);
      if (c == CH_NL) begin
         cur_line = sat(cur_line, LINE_TOP);
         cur_col = 1;
      end else begin
         cur_col = sat(cur_col, LINE_TOP);
      end
   endtask

   task automatic go_idle();
      lx_mode = MODE_IDLE;
      sflags = 4'd0;
      bmatch = 4'd0;
   endtask

   task automatic end_number();
      int unsigned back;
      if (lx_mode == MODE_NUM_EXP && !sflags[2]) begin
         back = 1 + sflags[3];
         put_err(ERR_EXP_DIGITS, cur_line, cur_col - back, cur_off - back, back);
      end
      put_tok(sflags[0] ? TOK_FLOAT : TOK_INT);
   endtask

   task automatic end_ident();
      if (sflags[0] && !sflags[1]) put_err(ERR_BARE_DOLLAR, tk_line, tk_col, tk_off, 1);
      put_tok((bmatch == 4'd5 || bmatch == 4'd10) ? TOK_BOOL : TOK_IDENT);
   endtask

   task automatic end_keyword();
      if (!sflags[1]) put_err(ERR_EMPTY_KW, tk_line, tk_col, tk_off, 1);
      put_tok(TOK_KEYWORD);
   endtask

   task automatic scan_byte(logic [7:0] c, logic [7:0] la);
      bit again;
      logic [7:0] v;
      do begin
         again = 1'b0;
         case (lx_mode)
            MODE_STR: begin
               advance(c);
               if (c == CH_QUOTE) begin
                  put_tok(TOK_STRING);
                  go_idle();
               end else if (c == CH_BSLASH) lx_mode = MODE_STR_ESC;
               else put_val(c);
            end
            MODE_STR_ESC: begin
               v = c;
               if (c == CH_LOW_N) v = CH_NL;
               else if (c == CH_LOW_T) v = CH_TAB;
               else if (c != CH_QUOTE && c != CH_BSLASH)
                  put_err(ERR_UNKNOWN_ESC, cur_line, cur_col - 1, cur_off - 1, 2);
               advance(c);
               put_val(v);
               lx_mode = MODE_STR;
            end
            MODE_NUM_INT, MODE_NUM_FRAC: begin
               if (dig(c)) begin
                  advance(c);
                  put_val(c);
               end else if (lx_mode == MODE_NUM_INT && c == CH_DOT && dig(la)) begin
                  advance(c);
                  put_val(c);
                  sflags[0] = 1'b1;
                  lx_mode = MODE_NUM_FRAC;
               end else if (c == CH_LOW_E || c == CH_UP_E) begin
                  advance(c);
                  put_val(c);
                  sflags[1:0] = 2'b11;
                  lx_mode = MODE_NUM_EXP;
               end else begin
                  end_number();
                  go_idle();
                  again = 1'b1;
               end
            end
            MODE_NUM_EXP: begin
               if (sflags[1] && (c == CH_PLUS || c == CH_MINUS)) begin
                  advance(c);
                  put_val(c);
                  sflags[1] = 1'b0;
                  sflags[3] = 1'b1;
               end else if (dig(c)) begin
                  advance(c);
                  put_val(c);
                  sflags[1] = 1'b0;
                  sflags[2] = 1'b1;
               end else begin
                  end_number();
                  go_idle();
                  again = 1'b1;
               end
            end
            MODE_KW_START: begin
               if (c == CH_QUOTE) begin
                  advance(c);
                  lx_mode = MODE_KWQ;
               end else begin
                  lx_mode = MODE_KW_BARE;
                  again = 1'b1;
               end
            end
            MODE_KW_BARE: begin
               if (idc(c) || dig(c)) begin
                  advance(c);
                  put_val(c);
                  sflags[1] = 1'b1;
               end else begin
                  end_keyword();
                  go_idle();
                  again = 1'b1;
               end
            end
            MODE_KWQ: begin
               advance(c);
               if (c == CH_QUOTE) begin
                  put_tok(TOK_KEYWORD);
                  go_idle();
               end else if (c == CH_BSLASH && la == CH_QUOTE) lx_mode = MODE_KWQ_TAKE;
               else put_val(c);
            end
            MODE_KWQ_TAKE: begin
               advance(c);
               put_val(c);
               lx_mode = MODE_KWQ;
            end
            MODE_IDENT: begin
               if (idc(c) || dig(c)) begin
                  advance(c);
                  put_val(c);
                  sflags[1] = 1'b1;
                  bmatch = bool_step(bmatch, c);
               end else begin
                  end_ident();
                  go_idle();
                  again = 1'b1;
               end
            end
            MODE_ARROW2: begin
               advance(c);
               put_tok(TOK_ARROW);
               go_idle();
            end
            MODE_CMT2: begin
               advance(c);
               lx_mode = MODE_COMMENT;
               sflags = 4'd1;
            end
            MODE_COMMENT: begin
               if (c == CH_NL) begin
                  if (keep_cmt) put_tok(TOK_COMMENT);
                  go_idle();
                  again = 1'b1;
               end else begin
                  advance(c);
                  if (!(sflags[0] && cmt_blank(c))) begin
                     sflags[0] = 1'b0;
                     if (keep_cmt) put_val(c);
                  end
               end
            end
            default: begin
               go_idle();
               if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL) begin
                  advance(c);
               end else begin
                  tk_line = cur_line;
                  tk_col = cur_col;
                  tk_off = cur_off;
                  if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACKET ||
                      c == CH_RBRACKET) begin
                     advance(c);
                     put_tok(c == CH_LPAREN ? TOK_LPAREN : c == CH_RPAREN ? TOK_RPAREN :
                             c == CH_LBRACKET ? TOK_LBRACKET : TOK_RBRACKET);
                  end else if (c == CH_QUOTE) begin
                     advance(c);
                     lx_mode = MODE_STR;
                  end else if (c == CH_SEMI && la == CH_SEMI) begin
                     advance(c);
                     lx_mode = MODE_CMT2;
                  end else if (c == CH_COLON) begin
                     advance(c);
                     lx_mode = MODE_KW_START;
                  end else if (c == CH_MINUS && la == CH_GT) begin
                     advance(c);
                     lx_mode = MODE_ARROW2;
                  end else if (c == CH_MINUS && dig(la)) begin
                     advance(c);
                     put_val(c);
                     lx_mode = MODE_NUM_INT;
                  end else if (dig(c)) begin
                     lx_mode = MODE_NUM_INT;
                     again = 1'b1;
                  end else if (c == CH_DOLLAR) begin
                     advance(c);
                     put_val(c);
                     sflags = 4'd1;
                     lx_mode = MODE_IDENT;
                  end else if (idc(c)) begin
                     bmatch = 4'd1;
                     lx_mode = MODE_IDENT;
                     again = 1'b1;
                  end else begin
                     put_err(ERR_UNEXPECTED, cur_line, cur_col, cur_off, 1);
                     advance(c);
                  end
               end
            end
         endcase
      end while (again);
   endtask

   task automatic close_source();
      case (lx_mode)
         MODE_STR_ESC: begin
            put_err(ERR_ESC_AT_END, cur_line, cur_col, cur_off, 1);
            put_err(ERR_OPEN_STRING, tk_line, tk_col, tk_off, open_span());
            put_tok(TOK_STRING);
         end
         MODE_STR: begin
            put_err(ERR_OPEN_STRING, tk_line, tk_col, tk_off, open_span());
            put_tok(TOK_STRING);
         end
         MODE_NUM_INT, MODE_NUM_FRAC, MODE_NUM_EXP: end_number();
         MODE_KW_START, MODE_KW_BARE: end_keyword();
         MODE_KWQ, MODE_KWQ_TAKE: begin
            put_err(ERR_OPEN_QKW, tk_line, tk_col, tk_off, open_span());
            put_tok(TOK_KEYWORD);
         end
         MODE_IDENT: end_ident();
         MODE_ARROW2: put_tok(TOK_ARROW);
         MODE_CMT2, MODE_COMMENT: if (keep_cmt) put_tok(TOK_COMMENT);
         default: ;
      endcase
      put(KIND_TOKEN, TOK_EOF, ERR_NONE, 8'd0, cur_line, cur_col, cur_off, 0, cur_line, cur_col);
      go_idle();
      hold_ch = 8'd0;
      hold_ok = 1'b0;
      cur_line = 1;
      cur_col = 1;
      cur_off = 0;
      tk_line = 1;
      tk_col = 1;
      tk_off = 0;
   endtask

   task automatic lex_step(logic [7:0] c, logic eos);
      step_n = 0;
      if (eos) begin
         if (hold_ok) scan_byte(hold_ch, 8'd0);
         close_source();
      end else begin
         if (hold_ok) scan_byte(hold_ch, c);
         hold_ch = c;
         hold_ok = 1'b1;
      end
      if (step_n > 0) record_q[record_q.size() - 1].last = 1'b1;
   endtask

   // Request side: the head of source_q is offered until its transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            lex_step(req_ch, req_end_of_source);
            void'(source_q.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (source_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_ch <= source_q[0].ch;
               req_end_of_source <= source_q[0].eos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: each transfer is checked against the oldest predicted record.
   always @(posedge clock) begin
      lex_record_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_record_kind, rsp_token_type, rsp_error_code, rsp_value_char,
                    rsp_start_line, rsp_start_column, rsp_start_offset, rsp_span_length,
                    rsp_end_line, rsp_end_column, rsp_last_record};
            if (record_q.size() == 0) begin
               $display("%0t: unexpected record %p", $time, got);
               failed = 1'b1;
            end else begin
               if (got !== record_q[0]) begin
                  $display("%0t: record mismatch: expected %p, actual %p", $time,
                           record_q[0], got);
                  failed = 1'b1;
               end
               void'(record_q.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** sexpr_lexer: FAILED **");
         $finish;
      end
   end

   task automatic push_ch(logic [7:0] c);
      source_q.push_back('{c, 1'b0});
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_ch(s[i]);
   endtask

   task automatic push_eos();
      source_q.push_back('{8'd0, 1'b1});
   endtask

   task automatic push_ident_chars(int n);
      for (int i = 0; i < n; i++) push_ch(ident_set[$urandom_range(ident_set.len() - 1)]);
   endtask

   task automatic push_digits(int n);
      for (int i = 0; i < n; i++) push_ch(8'("0" + $urandom_range(9)));
   endtask

   task automatic push_lexeme();
      int n;
      case ($urandom_range(13))
         0: push_ch($urandom_range(3) == 0 ? CH_LPAREN : $urandom_range(2) == 0 ? CH_RPAREN :
                    $urandom_range(1) ? CH_LBRACKET : CH_RBRACKET);
         1: begin
            push_ch(CH_QUOTE);
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(5))
                  0: push_text("\\n");
                  1: push_text("\\t");
                  2: push_text("\\\"");
                  3: begin
                     push_ch(CH_BSLASH);
                     push_ch(8'($urandom_range(255)));
                  end
                  default: push_ch(8'($urandom_range(32, 126) == CH_QUOTE ? "q" : "a" + i));
               endcase
            end
            if ($urandom_range(5) != 0) push_ch(CH_QUOTE);
         end
         2: begin
            if ($urandom_range(1)) push_ch(CH_MINUS);
            push_digits($urandom_range(1, 4));
         end
         3: begin
            push_digits($urandom_range(1, 3));
            if ($urandom_range(3) != 0) begin
               push_ch(CH_DOT);
               push_digits($urandom_range(3) == 0 ? 0 : $urandom_range(1, 3));
            end
            if ($urandom_range(1)) begin
               push_ch($urandom_range(1) ? CH_LOW_E : CH_UP_E);
               if ($urandom_range(1)) push_ch($urandom_range(1) ? CH_PLUS : CH_MINUS);
               push_digits($urandom_range(3) == 0 ? 0 : $urandom_range(1, 2));
            end
         end
         4: begin
            push_ch(CH_COLON);
            push_ident_chars($urandom_range(4));
         end
         5: begin
            push_text(":\"");
            n = $urandom_range(4);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(3) == 0) push_text("\\\"");
               else push_ch($urandom_range(1) ? CH_BSLASH : "k");
            end
            if ($urandom_range(5) != 0) push_ch(CH_QUOTE);
         end
         6: push_ident_chars($urandom_range(1, 5));
         7: case ($urandom_range(3))
               0: push_text("true");
               1: push_text("false");
               2: push_text("tru");
               default: push_text("falsey");
            endcase
         8: begin
            push_ch(CH_DOLLAR);
            push_ident_chars($urandom_range(3));
         end
         9: push_text($urandom_range(3) == 0 ? "-" : "->");
         10: begin
            push_text(";;");
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(4))
                  0: push_ch(CH_SPACE);
                  1: push_ch(CH_TAB);
                  2: push_ch(CH_CR);
                  3: push_ch(CH_VT);
                  default: push_ch(CH_FF);
               endcase
            end
            push_ident_chars($urandom_range(4));
            if ($urandom_range(4) != 0) push_ch(CH_NL);
         end
         11: push_ch($urandom_range(1) ? CH_NL : CH_TAB);
         12: push_ch(8'($urandom_range(255)));
         default: push_ch($urandom_range(1) ? CH_SEMI : CH_DOT);
      endcase
   endtask

   task automatic push_sources(int items);
      int target;
      target = source_q.size() + items;
      while (source_q.size() < target) begin
         repeat ($urandom_range(1, 8)) begin
            push_lexeme();
            case ($urandom_range(3))
               0: push_ch(CH_SPACE);
               1: push_ch(CH_NL);
               default: ;
            endcase
         end
         push_eos();
      end
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_KEEP_COMMENTS) keep_cmt = data[0];
   endtask

   task automatic wait_drained();
      while (source_q.size() != 0 || record_q.size() != 0 || req_valid) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      csr_write(ADDR_KEEP_COMMENTS, 32'd1);
      push_text("[\"a\\z\\");
      push_ch(8'hFF);
      push_eos();
      push_text("1e:");
      push_eos();
      push_text("$ ->;;");
      push_ch(8'h00);
      push_eos();
      push_text(":\"x");
      push_eos();
      push_sources(40);
      wait_drained();

      csr_write(ADDR_KEEP_COMMENTS, 32'd0);
      push_sources(150);
      wait_drained();

      send_idle_pct = 54;
      recv_stall_pct = 20;
      csr_write(ADDR_KEEP_COMMENTS, 32'd1);
      push_sources(150);
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      csr_write(ADDR_KEEP_COMMENTS, 32'hFFFF_FFFE);
      push_sources(130);
      wait_drained();

      if (!failed) begin
         $display("** sexpr_lexer: PASSED **");
      end else begin
         $display("** sexpr_lexer: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sexpr_lexer.f
src/sxl_pkg.sv
src/sexpr_lexer.sv
tb/tb_top.sv
